// ===== rtl/tpf_pkg.sv =====
// Package: shared types, constants and emit step codes for the template packet framer.
`default_nettype none

package tpf_pkg;

  // Default geometry of one template download.
  localparam int unsigned PAYLOAD_BYTES_DEF = 128;
  localparam int unsigned PACKET_COUNT_DEF  = 4;

  // Fixed header and command bytes.
  localparam logic [7:0] HDR_START_HI = 8'hEF;
  localparam logic [7:0] HDR_START_LO = 8'h01;
  localparam logic [7:0] ID_DATA      = 8'h02;
  localparam logic [7:0] ID_LAST      = 8'h08;
  localparam logic [7:0] CMD_PID      = 8'h01;
  localparam logic [7:0] CMD_LEN_HI   = 8'h00;
  localparam logic [7:0] CMD_LEN_LO   = 8'h04;
  localparam logic [7:0] CMD_DOWNLOAD = 8'h09;
  localparam logic [7:0] CMD_BUF_ID   = 8'h01;
  localparam logic [7:0] CMD_PAGE     = 8'h00;
  localparam logic [7:0] CMD_SUM_LO   = 8'h0F;

  localparam logic [31:0] ADDR_RESET = 32'hFFFF_FFFF;

  // Emit sequencer steps: command (13), header (9), data, checksum hi/lo.
  typedef logic [4:0] step_t;
  localparam step_t STEP_CMD  = 5'd0;
  localparam step_t STEP_HDR  = 5'd13;
  localparam step_t STEP_DATA = 5'd22;
  localparam step_t STEP_CSHI = 5'd23;
  localparam step_t STEP_CSLO = 5'd24;

  // One accepted beat with its position flags, handed to the emitter.
  typedef struct packed {
    logic [7:0]  data;
    logic        cmd;      // first byte of template: download command first
    logic        head;     // first byte of packet: header first
    logic        tail;     // last byte of packet: checksum after
    logic        last_pkt; // belongs to the final packet
    logic [7:0]  len_hi;
    logic [7:0]  len_lo;
    logic [15:0] csum;     // running sum including this byte
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/tpf_if.sv =====
// Interfaces: input beat, output beat and configuration write channels.
`default_nettype none

interface tpf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] template_byte;
  modport source (output valid, output template_byte, input ready);
  modport sink   (input valid, input template_byte, output ready);
endinterface

interface tpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       packet_end;
  logic       template_end;
  modport source (output valid, output out_byte, output run_last, output packet_end,
                  output template_end, input ready);
  modport sink   (input valid, input out_byte, input run_last, input packet_end,
                  input template_end, output ready);
endinterface

interface tpf_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] device_address;
  modport source (output valid, output device_address, input ready);
  modport sink   (input valid, input device_address, output ready);
endinterface

`default_nettype wire

// ===== rtl/tpf_emitter.sv =====
// Emitter: item stage, byte step sequencer and output register.
`default_nettype none

module tpf_emitter (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             item_valid_i,
  output logic                  item_ready_o,
  input  wire tpf_pkg::item_t   item_i,
  input  wire logic [31:0]      addr_i,
  tpf_out_if.source             out_o
);

  logic            item_v_q;
  tpf_pkg::item_t  item_q;
  tpf_pkg::step_t  step_q, step_start, step_end;
  logic            out_v_q;
  logic [7:0]      byte_q, byte_d;
  logic            last_q, pend_q, tend_q;
  logic            adv, fin;

  assign adv = !out_v_q || out_o.ready;
  assign step_end = item_q.tail ? tpf_pkg::STEP_CSLO : tpf_pkg::STEP_DATA;
  assign fin = item_v_q && adv && (step_q == step_end);
  assign item_ready_o = !item_v_q || fin;

  assign step_start = item_i.cmd  ? tpf_pkg::STEP_CMD :
                      item_i.head ? tpf_pkg::STEP_HDR : tpf_pkg::STEP_DATA;

  always_comb begin
    case (step_q)
      tpf_pkg::STEP_CMD:          byte_d = tpf_pkg::HDR_START_HI;
      tpf_pkg::STEP_CMD + 5'd1:   byte_d = tpf_pkg::HDR_START_LO;
      tpf_pkg::STEP_CMD + 5'd2:   byte_d = addr_i[31:24];
      tpf_pkg::STEP_CMD + 5'd3:   byte_d = addr_i[23:16];
      tpf_pkg::STEP_CMD + 5'd4:   byte_d = addr_i[15:8];
      tpf_pkg::STEP_CMD + 5'd5:   byte_d = addr_i[7:0];
      tpf_pkg::STEP_CMD + 5'd6:   byte_d = tpf_pkg::CMD_PID;
      tpf_pkg::STEP_CMD + 5'd7:   byte_d = tpf_pkg::CMD_LEN_HI;
      tpf_pkg::STEP_CMD + 5'd8:   byte_d = tpf_pkg::CMD_LEN_LO;
      tpf_pkg::STEP_CMD + 5'd9:   byte_d = tpf_pkg::CMD_DOWNLOAD;
      tpf_pkg::STEP_CMD + 5'd10:  byte_d = tpf_pkg::CMD_BUF_ID;
      tpf_pkg::STEP_CMD + 5'd11:  byte_d = tpf_pkg::CMD_PAGE;
      tpf_pkg::STEP_CMD + 5'd12:  byte_d = tpf_pkg::CMD_SUM_LO;
      tpf_pkg::STEP_HDR:          byte_d = tpf_pkg::HDR_START_HI;
      tpf_pkg::STEP_HDR + 5'd1:   byte_d = tpf_pkg::HDR_START_LO;
      tpf_pkg::STEP_HDR + 5'd2:   byte_d = addr_i[31:24];
      tpf_pkg::STEP_HDR + 5'd3:   byte_d = addr_i[23:16];
      tpf_pkg::STEP_HDR + 5'd4:   byte_d = addr_i[15:8];
      tpf_pkg::STEP_HDR + 5'd5:   byte_d = addr_i[7:0];
      tpf_pkg::STEP_HDR + 5'd6:   byte_d = item_q.last_pkt ? tpf_pkg::ID_LAST
                                                           : tpf_pkg::ID_DATA;
      tpf_pkg::STEP_HDR + 5'd7:   byte_d = item_q.len_hi;
      tpf_pkg::STEP_HDR + 5'd8:   byte_d = item_q.len_lo;
      tpf_pkg::STEP_DATA:         byte_d = item_q.data;
      tpf_pkg::STEP_CSHI:         byte_d = item_q.csum[15:8];
      tpf_pkg::STEP_CSLO:         byte_d = item_q.csum[7:0];
      default:                    byte_d = item_q.data;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q <= 1'b0;
      step_q   <= tpf_pkg::STEP_DATA;
      out_v_q  <= 1'b0;
    end else begin
      if (item_valid_i && item_ready_o) begin
        item_v_q <= 1'b1;
        step_q   <= step_start;
      end else if (fin) begin
        item_v_q <= 1'b0;
      end else if (item_v_q && adv) begin
        step_q <= step_q + 5'd1;
      end
      if (adv) begin
        out_v_q <= item_v_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (item_valid_i && item_ready_o) begin
      item_q <= item_i;
    end
    if (adv && item_v_q) begin
      byte_q <= byte_d;
      last_q <= (step_q == step_end);
      pend_q <= (step_q == tpf_pkg::STEP_CSLO);
      tend_q <= (step_q == tpf_pkg::STEP_CSLO) && item_q.last_pkt;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.out_byte     = byte_q;
  assign out_o.run_last     = last_q;
  assign out_o.packet_end   = pend_q;
  assign out_o.template_end = tend_q;

endmodule

`default_nettype wire

// ===== rtl/template_packet_framer.sv =====
// Top level: template byte stream to fingerprint module download packet framer.
//
//  channel  dir  payload                                          beat when
//  in_i     in   template_byte[7:0]                                valid & ready
//  out_o    out  out_byte[7:0], run_last, packet_end, template_end  valid & ready
//  cfg_i    in   device_address[31:0]                             valid & ready
//
// An input beat lands in the emitter's item stage and its output bytes leave
// through the output register. A plain data beat yields one output byte, so the
// block runs at one beat per cycle while out_o is ready; the first beat of a
// packet adds 9 header bytes, the first of a template 13 more, and the last of a
// packet 2 checksum bytes: that beat holds the item stage until all are sent.
// in_i.ready drops only while the item stage still has bytes left to send.
// rst_ni clears position, sum and valids; device_address resets to all ones.
`default_nettype none

module template_packet_framer #(
  parameter int unsigned PAYLOAD_BYTES = tpf_pkg::PAYLOAD_BYTES_DEF,
  parameter int unsigned PACKET_COUNT  = tpf_pkg::PACKET_COUNT_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tpf_in_if.sink     in_i,
  tpf_cfg_if.sink    cfg_i,
  tpf_out_if.source  out_o
);

  localparam int unsigned OFF_W = $clog2(PAYLOAD_BYTES);
  localparam int unsigned PKT_W = (PACKET_COUNT > 1) ? $clog2(PACKET_COUNT) : 1;
  localparam logic [15:0] LEN   = 16'(PAYLOAD_BYTES + 2);
  localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(PAYLOAD_BYTES - 1);
  localparam logic [PKT_W-1:0] PKT_LAST = PKT_W'(PACKET_COUNT - 1);

  // Device address register; config port never stalls.
  logic [31:0] addr_q;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= tpf_pkg::ADDR_RESET;
    end else if (cfg_i.valid) begin
      addr_q <= cfg_i.device_address;
    end
  end

  // Position within template: byte offset inside packet plus packet number.
  logic [OFF_W-1:0] off_q;
  logic [PKT_W-1:0] pkt_q;
  logic [15:0]      sum_q, sum_base, sum_d;
  logic             head, tail, last_pkt, accept, item_ready;
  logic [7:0]       id;
  tpf_pkg::item_t   item;

  assign head     = (off_q == '0);
  assign tail     = (off_q == OFF_LAST);
  assign last_pkt = (pkt_q == PKT_LAST);
  assign id       = last_pkt ? tpf_pkg::ID_LAST : tpf_pkg::ID_DATA;

  // Header seeds the sum with id and both length bytes.
  assign sum_base = head ? (16'(id) + 16'(LEN[15:8]) + 16'(LEN[7:0])) : sum_q;
  assign sum_d    = sum_base + 16'(in_i.template_byte);

  assign in_i.ready = item_ready;
  assign accept     = in_i.valid && item_ready;

  always_comb begin
    item.data     = in_i.template_byte;
    item.cmd      = head && (pkt_q == '0);
    item.head     = head;
    item.tail     = tail;
    item.last_pkt = last_pkt;
    item.len_hi   = LEN[15:8];
    item.len_lo   = LEN[7:0];
    item.csum     = sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
      pkt_q <= '0;
      sum_q <= '0;
    end else if (accept) begin
      sum_q <= sum_d;
      if (tail) begin
        off_q <= '0;
        pkt_q <= last_pkt ? '0 : pkt_q + PKT_W'(1);
      end else begin
        off_q <= off_q + OFF_W'(1);
      end
    end
  end

  tpf_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_i.valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .addr_i       (addr_q),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for the template packet framer: predicts the framed byte stream and checks every beat.
`timescale 1ns / 100ps

module tb;
  import tpf_pkg::*;

  // Block geometry at its defaults: four packets of 128 bytes, 512 per template.
  localparam int unsigned PAYLOAD = PAYLOAD_BYTES_DEF;
  localparam int unsigned PACKETS = PACKET_COUNT_DEF;
  localparam int unsigned TOTAL   = PAYLOAD * PACKETS;
  localparam logic [15:0] PKT_LEN = 16'(PAYLOAD + 2);

  // Run guard and the length of the long receiver hold-off.
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TAIL_CYCLES  = 30;

  // One output beat as the framer should produce it.
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       packet_end;
    logic       template_end;
  } tx_beat_t;

  logic clk;
  logic rst_n;

  tpf_in_if  in_if ();
  tpf_cfg_if cfg_if ();
  tpf_out_if out_if ();

  template_packet_framer uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  // Expected framed bytes, oldest first.
  tx_beat_t tx_expect[$];

  // Shadow of the framer: address register, template position, packet sum.
  logic [31:0] addr_shadow;
  logic [8:0]  tpl_pos;
  logic [15:0] pkt_sum;

  // Idle percentages for sender and receiver; set only away from the rising edge.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // Long hold-off request: the test bumps hold_req, the receiver answers.
  int unsigned hold_req;
  int unsigned hold_ack;
  int unsigned hold_left;

  int unsigned errors;
  int unsigned bytes_in;
  int unsigned beats_out;
  int unsigned templates_done;
  int unsigned addr_writes;
  int unsigned cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void push_beat(logic [7:0] d, logic rl, logic pe, logic te);
    tx_expect.push_back(tx_beat_t'{d, rl, pe, te});
  endfunction

  // EF 01 and the address, MSB first; shared by the command and each packet.
  function automatic void push_header();
    push_beat(HDR_START_HI, 1'b0, 1'b0, 1'b0);
    push_beat(HDR_START_LO, 1'b0, 1'b0, 1'b0);
    push_beat(addr_shadow[31:24], 1'b0, 1'b0, 1'b0);
    push_beat(addr_shadow[23:16], 1'b0, 1'b0, 1'b0);
    push_beat(addr_shadow[15:8], 1'b0, 1'b0, 1'b0);
    push_beat(addr_shadow[7:0], 1'b0, 1'b0, 1'b0);
  endfunction

  // Everything one template byte causes, in order, with the shadow state advanced.
  function automatic void frame_byte(logic [7:0] d);
    int unsigned pkt;
    int unsigned off;
    logic        last_pkt;
    logic [7:0]  pid;
    pkt      = int'(tpl_pos) / PAYLOAD;
    off      = int'(tpl_pos) % PAYLOAD;
    last_pkt = (pkt == PACKETS - 1);

    // first byte of a template: download command; its sum ignores the address
    if (tpl_pos == 9'd0) begin
      push_header();
      push_beat(CMD_PID, 1'b0, 1'b0, 1'b0);
      push_beat(CMD_LEN_HI, 1'b0, 1'b0, 1'b0);
      push_beat(CMD_LEN_LO, 1'b0, 1'b0, 1'b0);
      push_beat(CMD_DOWNLOAD, 1'b0, 1'b0, 1'b0);
      push_beat(CMD_BUF_ID, 1'b0, 1'b0, 1'b0);
      push_beat(CMD_PAGE, 1'b0, 1'b0, 1'b0);
      push_beat(CMD_SUM_LO, 1'b0, 1'b0, 1'b0);
    end

    // first byte of a packet: header; the sum restarts from id and length
    if (off == 0) begin
      pid = last_pkt ? ID_LAST : ID_DATA;
      push_header();
      push_beat(pid, 1'b0, 1'b0, 1'b0);
      push_beat(PKT_LEN[15:8], 1'b0, 1'b0, 1'b0);
      push_beat(PKT_LEN[7:0], 1'b0, 1'b0, 1'b0);
      pkt_sum = 16'(pid) + 16'(PKT_LEN[15:8]) + 16'(PKT_LEN[7:0]);
    end

    pkt_sum = pkt_sum + 16'(d);
    push_beat(d, off != PAYLOAD - 1, 1'b0, 1'b0);

    // last byte of a packet: checksum, high byte first
    if (off == PAYLOAD - 1) begin
      push_beat(pkt_sum[15:8], 1'b0, 1'b0, 1'b0);
      push_beat(pkt_sum[7:0], 1'b1, 1'b1, last_pkt);
    end

    if (tpl_pos == 9'(TOTAL - 1)) begin
      tpl_pos = 9'd0;
      templates_done++;
    end else begin
      tpl_pos = tpl_pos + 9'd1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Offer one template byte, maybe after a gap; returns on the accepting edge.
  task automatic send_byte(input logic [7:0] d);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.template_byte <= d;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    frame_byte(d);
    bytes_in++;
  endtask

  // Drop valid and wait for every expected byte to come out.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (tx_expect.size() != 0) @(posedge clk);
  endtask

  // Address write; only called with the framer idle.
  task automatic write_address(input logic [31:0] a);
    cfg_if.valid          <= 1'b1;
    cfg_if.device_address <= a;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
    addr_shadow = a;
    addr_writes++;
  endtask

  // Idle knobs change on the falling edge so the receiver never races them.
  task automatic set_idle(input int unsigned s_pct, input int unsigned r_pct);
    @(negedge clk);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    @(posedge clk);
  endtask

  // Receiver: random ready, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_ack != hold_req) begin
      hold_ack     <= hold_req;
      hold_left    <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    tx_beat_t got;
    tx_beat_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = tx_beat_t'{out_if.out_byte, out_if.run_last, out_if.packet_end,
                       out_if.template_end};
      beats_out++;
      if (tx_expect.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat byte=%h last=%b pend=%b tend=%b", $time,
                 got.data, got.run_last, got.packet_end, got.template_end);
      end else begin
        want = tx_expect.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: beat mismatch expected byte=%h last=%b pend=%b tend=%b",
                   $time, want.data, want.run_last, want.packet_end, want.template_end);
          $display("%0t:                 actual byte=%h last=%b pend=%b tend=%b",
                   $time, got.data, got.run_last, got.packet_end, got.template_end);
        end
      end
    end
  end

  // Run guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles, %0d beats still expected", $time, cycles,
               tx_expect.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes and bit patterns right after reset, so the command and the
  // first header carry the reset address.
  task automatic test_byte_extremes();
    logic [7:0] pats[10];
    pats = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'h0F, 8'hF0};
    foreach (pats[i]) send_byte(pats[i]);
    drain();
  endtask

  // All-zero address; takes effect at the next header, which comes later.
  task automatic test_zero_address();
    write_address(32'h0000_0000);
    for (int i = 0; i < 15; i++) send_byte(8'($urandom_range(255)));
    drain();
  endtask

  // Random bytes under a given idling mix, then a new address for what follows.
  task automatic test_random_stream(input int unsigned n, input int unsigned s_pct,
                                    input int unsigned r_pct, input logic [31:0] next_addr);
    set_idle(s_pct, r_pct);
    for (int unsigned i = 0; i < n; i++) send_byte(8'($urandom_range(255)));
    drain();
    write_address(next_addr);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // bytes back to back, so the item stage fills and input ready drops.
  // This phase also runs across the end of the template and into the next.
  task automatic test_backpressure(input int unsigned n);
    set_idle(0, 0);
    @(negedge clk);
    hold_req = hold_req + 1;
    @(posedge clk);
    for (int unsigned i = 0; i < n; i++) send_byte(8'($urandom_range(255)));
    drain();
  endtask

  initial begin
    rst_n                 = 1'b0;
    in_if.valid           = 1'b0;
    in_if.template_byte   = 8'h00;
    cfg_if.valid          = 1'b0;
    cfg_if.device_address = 32'h0000_0000;
    addr_shadow           = ADDR_RESET;
    tpl_pos               = 9'd0;
    pkt_sum               = 16'h0000;
    send_idle_pct         = 0;
    recv_idle_pct         = 0;
    hold_req              = 0;
    hold_ack              = 0;
    hold_left             = 0;
    errors                = 0;
    bytes_in              = 0;
    beats_out             = 0;
    templates_done        = 0;
    addr_writes           = 0;
    cycles                = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_byte_extremes();
    test_zero_address();
    test_random_stream(157, 38, 57, $urandom());
    test_random_stream(157, 57, 38, 32'h8000_0001);
    test_random_stream(156, 0, 0, 32'hFFFF_FFFF);
    test_backpressure(60);

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run: %0d template bytes in, %0d framed beats out, %0d full templates,",
             bytes_in, beats_out, templates_done);
    $display("     %0d address writes incl. all zeros and all ones, long output hold-off",
             addr_writes);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d errors", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tpf_pkg.sv
rtl/tpf_if.sv
rtl/tpf_emitter.sv
rtl/template_packet_framer.sv
verif/tb.sv
